// File: rtl/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared constants, select codes and controller/datapath command and status
// types for the disjoint-set cycle and prefix-cover engine.
// ----------------------------------------------------------------------------
package ufc_pkg;

   localparam int NODES_DEF = 16384;   // default node count
   localparam int IN_W      = 14;      // width of label and count fields
   localparam int KW        = 4;       // width of the label reduction step counter

   localparam logic ACT_JOIN    = 1'b0;
   localparam logic ACT_FINISH  = 1'b1;
   localparam logic KIND_JOIN   = 1'b0;
   localparam logic KIND_PREFIX = 1'b1;

   // parent read address select
   typedef enum logic [1:0] {
      PR_LAB = 2'd0,
      PR_Q   = 2'd1,
      PR_CNT = 2'd2
   } par_rsel_type;

   // size/flag read address select
   typedef enum logic [1:0] {
      AX_ROOT = 2'd0,
      AX_RA   = 2'd1,
      AX_CUR  = 2'd2
   } aux_rsel_type;

   typedef enum logic [1:0] {
      PW_CLEAR = 2'd0,
      PW_COMP  = 2'd1,
      PW_LINK  = 2'd2
   } par_wsel_type;

   typedef enum logic [1:0] {
      SW_CLEAR = 2'd0,
      SW_SUM   = 2'd1,
      SW_DEC   = 2'd2
   } size_wsel_type;

   typedef enum logic [1:0] {
      FW_CLEAR = 2'd0,
      FW_SET   = 2'd1,
      FW_OR    = 2'd2
   } flag_wsel_type;

   typedef struct packed {
      logic          load_in;
      logic          red_step;
      logic          sel_b;
      logic          par_rd;
      par_rsel_type  par_sel;
      logic          root_set;
      logic          ra_set;
      logic          aux_rd;
      aux_rsel_type  aux_sel;
      logic          par_we;
      par_wsel_type  par_wsel;
      logic          size_we;
      size_wsel_type size_wsel;
      logic          flag_we;
      flag_wsel_type flag_wsel;
      logic          cap_rb;
      logic          cnt_clr;
      logic          cnt_one;
      logic          cnt_inc;
      logic          cov_last;
      logic          cov_full;
      logic          res_join;
      logic          res_fin;
   } ufc_cmd_type;

   typedef struct packed {
      logic q_eq_cur;
      logic q_eq_root;
      logic lab_eq_root;
      logic ra_eq_root;
      logic flag_q;
      logic size_le1;
      logic cnt_last;
      logic red_last;
      logic red_skip;
   } ufc_sts_type;

endpackage

// File: rtl/ufc_req_if.sv
// ----------------------------------------------------------------------------
// ufc_req_if
// Request channel: valid/ready handshake carrying one join or finish item.
// ----------------------------------------------------------------------------
interface ufc_req_if import ufc_pkg::*; ();

   logic            valid;
   logic            ready;
   logic            action;
   logic [IN_W-1:0] node_a;
   logic [IN_W-1:0] node_b;

   modport source (output valid, output action, output node_a, output node_b,
                   input ready);
   modport sink   (input valid, input action, input node_a, input node_b,
                   output ready);

endinterface

// File: rtl/ufc_rsp_if.sv
// ----------------------------------------------------------------------------
// ufc_rsp_if
// Response channel: valid/ready handshake carrying one result per item.
// ----------------------------------------------------------------------------
interface ufc_rsp_if import ufc_pkg::*; ();

   logic            valid;
   logic            ready;
   logic            result_kind;
   logic [IN_W-1:0] set_root;
   logic            closed_cycle;
   logic [IN_W-1:0] covered_count;

   modport source (output valid, output result_kind, output set_root,
                   output closed_cycle, output covered_count, input ready);
   modport sink   (input valid, input result_kind, input set_root,
                   input closed_cycle, input covered_count, output ready);

endinterface

// File: rtl/union_find_cycle_prefix_cover.sv
// ----------------------------------------------------------------------------
// union_find_cycle_prefix_cover
// Disjoint-set engine with cycle marking and a covered-prefix answer.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per transaction: action 0 joins node_a with
//   node_b, action 1 asks for the covered prefix. Labels are taken modulo
//   NODES. rsp_chan returns exactly one result per item, in order.
//   Items are handled one at a time; req_chan.ready is high only while the
//   engine is waiting for work.
//   Join: the labels are reduced (skipped when NODES is a power of two or
//   at least 2**14), then for each label the parent chain is walked to
//   the root and compressed onto it (skipped when the node is its own
//   root); the two sets are merged unless both roots match, and the
//   result is loaded. The engine then waits for work again.
//   Finish: per label the parent chain is walked to the root and the set
//   is checked; the result is loaded, then a clearing pass over all NODES
//   entries restores the tables; the result is already offered in that pass.
//   Reset: synchronous; a clearing pass follows, during which no item
//   is taken.
//   A stalled receiver holds the result in the output register; the next
//   item is still accepted and worked on, and waits only to hand over its
//   own result.
// ----------------------------------------------------------------------------
module union_find_cycle_prefix_cover import ufc_pkg::*; #(
   parameter int NODES = NODES_DEF
) (
   input logic        clock,
   input logic        reset,
   ufc_req_if.sink    req_chan,
   ufc_rsp_if.source  rsp_chan
);

   ufc_cmd_type cmd;
   ufc_sts_type sts;

   ufc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   ufc_dpath #(
      .NODES (NODES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_node_a  (req_chan.node_a),
      .in_node_b  (req_chan.node_b),
      .res_kind   (rsp_chan.result_kind),
      .res_root   (rsp_chan.set_root),
      .res_closed (rsp_chan.closed_cycle),
      .res_cov    (rsp_chan.covered_count)
   );

endmodule

// File: rtl/ufc_dpath.sv
// ----------------------------------------------------------------------------
// ufc_dpath
// Datapath: parent, size and cycle-flag memories, walk pointers, label
// reduction, counters and the result register.
// ----------------------------------------------------------------------------
module ufc_dpath import ufc_pkg::*; #(
   parameter int NODES = NODES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  ufc_cmd_type     cmd,
   output ufc_sts_type     sts,
   input  logic [IN_W-1:0] in_node_a,
   input  logic [IN_W-1:0] in_node_b,
   output logic            res_kind,
   output logic [IN_W-1:0] res_root,
   output logic            res_closed,
   output logic [IN_W-1:0] res_cov
);

   localparam int LW = $clog2(NODES);
   localparam int SW = LW + 1;
   localparam int RW = 2 * IN_W;
   localparam bit POW2 = (NODES & (NODES - 1)) == 0;
   localparam bit SMALL = NODES < (1 << IN_W);
   localparam bit NEED_RED = SMALL && !POW2;
   localparam logic [IN_W-1:0] LOAD_MASK = (SMALL && POW2) ? IN_W'(NODES - 1) : '1;
   localparam logic [KW-1:0] KTOP = NEED_RED ? KW'(IN_W - $clog2(NODES)) : '0;
   localparam logic [LW-1:0] LAST = LW'(NODES - 1);

   logic [LW-1:0] par_mem  [NODES];
   logic [SW-1:0] size_mem [NODES];
   logic          flag_mem [NODES];

   logic [IN_W-1:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [KW-1:0]   kcnt_ff, kcnt_in;
   logic [LW-1:0]   cur_ff, cur_in, root_ff, root_in, ra_ff, ra_in;
   logic [LW-1:0]   cnt_ff, cnt_in, cov_ff, cov_in;
   logic            fb_ff, fb_in;
   logic [SW-1:0]   sb_ff, sb_in;
   logic [LW-1:0]   par_q_ff;
   logic [SW-1:0]   size_q_ff;
   logic            flag_q_ff;
   logic            res_kind_ff, res_kind_in, res_closed_ff, res_closed_in;
   logic [IN_W-1:0] res_root_ff, res_root_in, res_cov_ff, res_cov_in;

   logic [RW-1:0]   dv;
   logic [LW-1:0]   lab_a, lab_b, lab_sel;
   logic [LW-1:0]   par_raddr, aux_raddr;
   logic [LW-1:0]   par_waddr, par_wdata, size_waddr, flag_waddr;
   logic [SW-1:0]   size_wdata;
   logic            flag_wdata;

   assign lab_a   = LW'(rem_a_ff);
   assign lab_b   = LW'(rem_b_ff);
   assign lab_sel = cmd.sel_b ? lab_b : lab_a;
   assign dv      = RW'(NODES) << kcnt_ff;

   always_comb begin
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      kcnt_in  = kcnt_ff;
      if (cmd.load_in) begin
         rem_a_in = in_node_a & LOAD_MASK;
         rem_b_in = in_node_b & LOAD_MASK;
         kcnt_in  = KTOP;
      end else if (cmd.red_step) begin
         // one restoring remainder step per cycle on both labels
         if (RW'(rem_a_ff) >= dv) begin
            rem_a_in = rem_a_ff - dv[IN_W-1:0];
         end
         if (RW'(rem_b_ff) >= dv) begin
            rem_b_in = rem_b_ff - dv[IN_W-1:0];
         end
         kcnt_in = kcnt_ff - KW'(1);
      end
   end

   always_comb begin
      case (cmd.par_sel)
         PR_LAB:  par_raddr = lab_sel;
         PR_Q:    par_raddr = par_q_ff;
         PR_CNT:  par_raddr = cnt_ff;
         default: par_raddr = par_q_ff;
      endcase
      case (cmd.aux_sel)
         AX_ROOT: aux_raddr = root_ff;
         AX_RA:   aux_raddr = ra_ff;
         AX_CUR:  aux_raddr = cur_ff;
         default: aux_raddr = root_ff;
      endcase
      case (cmd.par_wsel)
         PW_CLEAR: begin
            par_waddr = cnt_ff;
            par_wdata = cnt_ff;
         end
         PW_COMP: begin
            par_waddr = cur_ff;
            par_wdata = root_ff;
         end
         PW_LINK: begin
            par_waddr = root_ff;
            par_wdata = ra_ff;
         end
         default: begin
            par_waddr = cnt_ff;
            par_wdata = cnt_ff;
         end
      endcase
      case (cmd.size_wsel)
         SW_CLEAR: begin
            size_waddr = cnt_ff;
            size_wdata = SW'(1);
         end
         SW_SUM: begin
            size_waddr = ra_ff;
            size_wdata = size_q_ff + sb_ff;
         end
         SW_DEC: begin
            size_waddr = root_ff;
            size_wdata = size_q_ff - SW'(1);
         end
         default: begin
            size_waddr = cnt_ff;
            size_wdata = SW'(1);
         end
      endcase
      case (cmd.flag_wsel)
         FW_CLEAR: begin
            flag_waddr = cnt_ff;
            flag_wdata = 1'b0;
         end
         FW_SET: begin
            flag_waddr = ra_ff;
            flag_wdata = 1'b1;
         end
         FW_OR: begin
            flag_waddr = ra_ff;
            flag_wdata = flag_q_ff | fb_ff;
         end
         default: begin
            flag_waddr = cnt_ff;
            flag_wdata = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.par_we) begin
         par_mem[par_waddr] <= par_wdata;
      end
      if (cmd.par_rd) begin
         par_q_ff <= par_mem[par_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      if (cmd.aux_rd) begin
         size_q_ff <= size_mem[aux_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flag_we) begin
         flag_mem[flag_waddr] <= flag_wdata;
      end
      if (cmd.aux_rd) begin
         flag_q_ff <= flag_mem[aux_raddr];
      end
   end

   always_comb begin
      // cur follows the last parent read address
      cur_in  = cmd.par_rd ? par_raddr : cur_ff;
      root_in = cmd.root_set ? cur_ff : root_ff;
      ra_in   = cmd.ra_set ? root_ff : ra_ff;
      fb_in   = cmd.cap_rb ? flag_q_ff : fb_ff;
      sb_in   = cmd.cap_rb ? size_q_ff : sb_ff;

      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_one) begin
         cnt_in = LW'(1);
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + LW'(1);
      end

      cov_in = cov_ff;
      if (cmd.cov_last) begin
         cov_in = cnt_ff - LW'(1);
      end else if (cmd.cov_full) begin
         cov_in = LAST;
      end

      res_kind_in   = res_kind_ff;
      res_root_in   = res_root_ff;
      res_closed_in = res_closed_ff;
      res_cov_in    = res_cov_ff;
      if (cmd.res_join) begin
         res_kind_in   = KIND_JOIN;
         res_root_in   = IN_W'(ra_ff);
         res_closed_in = (ra_ff == root_ff);
         res_cov_in    = '0;
      end else if (cmd.res_fin) begin
         res_kind_in   = KIND_PREFIX;
         res_root_in   = '0;
         res_closed_in = 1'b0;
         res_cov_in    = IN_W'(cov_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_a_ff      <= rem_a_in;
      rem_b_ff      <= rem_b_in;
      kcnt_ff       <= kcnt_in;
      cur_ff        <= cur_in;
      root_ff       <= root_in;
      ra_ff         <= ra_in;
      fb_ff         <= fb_in;
      sb_ff         <= sb_in;
      cov_ff        <= cov_in;
      res_kind_ff   <= res_kind_in;
      res_root_ff   <= res_root_in;
      res_closed_ff <= res_closed_in;
      res_cov_ff    <= res_cov_in;
   end

   always_comb begin
      sts.q_eq_cur    = (par_q_ff == cur_ff);
      sts.q_eq_root   = (par_q_ff == root_ff);
      sts.lab_eq_root = (lab_sel == root_ff);
      sts.ra_eq_root  = (ra_ff == root_ff);
      sts.flag_q      = flag_q_ff;
      sts.size_le1    = (size_q_ff <= SW'(1));
      sts.cnt_last    = (cnt_ff == LAST);
      sts.red_last    = (kcnt_ff == '0);
      sts.red_skip    = !NEED_RED;
   end

   assign res_kind   = res_kind_ff;
   assign res_root   = res_root_ff;
   assign res_closed = res_closed_ff;
   assign res_cov    = res_cov_ff;

endmodule

// File: rtl/ufc_ctrl.sv
// ----------------------------------------------------------------------------
// ufc_ctrl
// Controller: sequences the clearing pass, label reduction, root walks with
// path compression, set merge, the finish walk and the response handshake.
// ----------------------------------------------------------------------------
module ufc_ctrl import ufc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_action,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ufc_cmd_type cmd,
   input  ufc_sts_type sts
);

   typedef enum logic [15:0] {
      S_CLEAR  = 16'h0001,
      S_IDLE   = 16'h0002,
      S_RED    = 16'h0004,
      S_FSTART = 16'h0008,
      S_FIND   = 16'h0010,
      S_CSTART = 16'h0020,
      S_COMP   = 16'h0040,
      S_FEND   = 16'h0080,
      S_MRG    = 16'h0100,
      S_MRG2   = 16'h0200,
      S_MRG3   = 16'h0400,
      S_JRESP  = 16'h0800,
      S_WSTART = 16'h1000,
      S_WFIND  = 16'h2000,
      S_WCHK   = 16'h4000,
      S_FRESP  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load_rsp;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      cmd.sel_b = phase_ff;
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.par_we    = 1'b1;
            cmd.par_wsel  = PW_CLEAR;
            cmd.size_we   = 1'b1;
            cmd.size_wsel = SW_CLEAR;
            cmd.flag_we   = 1'b1;
            cmd.flag_wsel = FW_CLEAR;
            if (sts.cnt_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               phase_in    = 1'b0;
               if (req_action == ACT_FINISH) begin
                  cmd.cnt_one = 1'b1;
                  state_in    = S_WSTART;
               end else if (sts.red_skip) begin
                  state_in = S_FSTART;
               end else begin
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            cmd.red_step = 1'b1;
            if (sts.red_last) begin
               state_in = S_FSTART;
            end
         end
         S_FSTART: begin
            cmd.par_rd  = 1'b1;
            cmd.par_sel = PR_LAB;
            state_in    = S_FIND;
         end
         S_FIND: begin
            if (sts.q_eq_cur) begin
               cmd.root_set = 1'b1;
               state_in     = S_CSTART;
            end else begin
               cmd.par_rd  = 1'b1;
               cmd.par_sel = PR_Q;
            end
         end
         S_CSTART: begin
            if (sts.lab_eq_root) begin
               state_in = S_FEND;
            end else begin
               cmd.par_rd  = 1'b1;
               cmd.par_sel = PR_LAB;
               state_in    = S_COMP;
            end
         end
         S_COMP: begin
            // point the visited node at the root, advance along the old link
            cmd.par_we   = 1'b1;
            cmd.par_wsel = PW_COMP;
            if (sts.q_eq_root) begin
               state_in = S_FEND;
            end else begin
               cmd.par_rd  = 1'b1;
               cmd.par_sel = PR_Q;
            end
         end
         S_FEND: begin
            if (!phase_ff) begin
               cmd.ra_set = 1'b1;
               phase_in   = 1'b1;
               state_in   = S_FSTART;
            end else begin
               state_in = S_MRG;
            end
         end
         S_MRG: begin
            if (sts.ra_eq_root) begin
               cmd.flag_we   = 1'b1;
               cmd.flag_wsel = FW_SET;
               state_in      = S_JRESP;
            end else begin
               cmd.aux_rd  = 1'b1;
               cmd.aux_sel = AX_ROOT;
               state_in    = S_MRG2;
            end
         end
         S_MRG2: begin
            cmd.cap_rb  = 1'b1;
            cmd.aux_rd  = 1'b1;
            cmd.aux_sel = AX_RA;
            state_in    = S_MRG3;
         end
         S_MRG3: begin
            cmd.par_we    = 1'b1;
            cmd.par_wsel  = PW_LINK;
            cmd.size_we   = 1'b1;
            cmd.size_wsel = SW_SUM;
            cmd.flag_we   = 1'b1;
            cmd.flag_wsel = FW_OR;
            state_in      = S_JRESP;
         end
         S_JRESP: begin
            if (out_free) begin
               cmd.res_join = 1'b1;
               load_rsp     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WSTART: begin
            cmd.par_rd  = 1'b1;
            cmd.par_sel = PR_CNT;
            state_in    = S_WFIND;
         end
         S_WFIND: begin
            if (sts.q_eq_cur) begin
               cmd.root_set = 1'b1;
               cmd.aux_rd   = 1'b1;
               cmd.aux_sel  = AX_CUR;
               state_in     = S_WCHK;
            end else begin
               cmd.par_rd  = 1'b1;
               cmd.par_sel = PR_Q;
            end
         end
         S_WCHK: begin
            if (!sts.flag_q && sts.size_le1) begin
               cmd.cov_last = 1'b1;
               state_in     = S_FRESP;
            end else begin
               if (!sts.flag_q) begin
                  // use up one member of an acyclic set
                  cmd.size_we   = 1'b1;
                  cmd.size_wsel = SW_DEC;
               end
               if (sts.cnt_last) begin
                  cmd.cov_full = 1'b1;
                  state_in     = S_FRESP;
               end else begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_WSTART;
               end
            end
         end
         S_FRESP: begin
            if (out_free) begin
               cmd.res_fin = 1'b1;
               cmd.cnt_clr = 1'b1;
               load_rsp    = 1'b1;
               state_in    = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/ufc_chk.sv
// ----------------------------------------------------------------------------
// ufc_chk
// Port-level checks for the disjoint-set engine, bound to the top level.
// ----------------------------------------------------------------------------
module ufc_chk import ufc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic            rsp_result_kind,
   input logic [IN_W-1:0] rsp_set_root,
   input logic            rsp_closed_cycle,
   input logic [IN_W-1:0] rsp_covered_count
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_set_root) && $stable(rsp_closed_cycle) && $stable(rsp_covered_count))
      else $error("result changed while stalled");

   // clearing pass keeps the request side closed after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // one item at a time: an accepted request closes the request side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_join_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_JOIN |-> rsp_covered_count == '0)
      else $error("join result carries a count");

   a_prefix_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_PREFIX |->
      rsp_set_root == '0 && !rsp_closed_cycle)
      else $error("prefix result carries join fields");

endmodule

bind union_find_cycle_prefix_cover ufc_chk u_ufc_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_result_kind   (rsp_chan.result_kind),
   .rsp_set_root      (rsp_chan.set_root),
   .rsp_closed_cycle  (rsp_chan.closed_cycle),
   .rsp_covered_count (rsp_chan.covered_count)
);

// File: sim/union_find_cycle_prefix_cover_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_cycle_prefix_cover_test
// Self-checking bench for the disjoint-set cycle and prefix-cover engine.
// Joins and finish requests go in over the request channel with random gaps.
// A scoreboard keeps its own forest of parents, set sizes and cycle flags and
// predicts every response. Responses are taken under random backpressure and
// checked in order.
// ----------------------------------------------------------------------------
module union_find_cycle_prefix_cover_test;
   import ufc_pkg::*;

   localparam int NODES       = NODES_DEF;
   localparam int TOTAL_ITEMS = 1050;
   localparam int QUIET_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic            kind;
      logic [IN_W-1:0] root;
      logic            closed;
      logic [IN_W-1:0] count;
   } cover_result_type;

   class ufc_cover_scoreboard;
      int unsigned      parent_of [NODES];
      int unsigned      members [NODES];
      bit               cyclic [NODES];
      cover_result_type answers_q [$];
      int               errors;
      int               responses;
      int               joins;
      int               cycles_closed;
      int               finishes;
      int               best_cover;

      function new();
         clear_forest();
      endfunction

      function void clear_forest();
         for (int i = 0; i < NODES; i++) begin
            parent_of[i] = i;
            members[i]   = 1;
            cyclic[i]    = 1'b0;
         end
      endfunction

      function int unsigned find_root(int unsigned x);
         int unsigned r;
         int unsigned nxt;
         r = x;
         while (parent_of[r] != r) r = parent_of[r];
         // compress the walked chain onto the root
         while (x != r) begin
            nxt          = parent_of[x];
            parent_of[x] = r;
            x            = nxt;
         end
         return r;
      endfunction

      function void note_request(logic act, logic [IN_W-1:0] a, logic [IN_W-1:0] b);
         cover_result_type want;
         int unsigned      ra;
         int unsigned      rb;
         int unsigned      id;
         int unsigned      covered;
         want = '0;
         if (act == ACT_JOIN) begin
            ra = find_root(int'(a) % NODES);
            rb = find_root(int'(b) % NODES);
            want.kind = KIND_JOIN;
            want.root = ra[IN_W-1:0];
            if (ra == rb) begin
               cyclic[ra]  = 1'b1;
               want.closed = 1'b1;
               cycles_closed++;
            end else begin
               cyclic[ra]    = cyclic[ra] | cyclic[rb];
               members[ra]  += members[rb];
               parent_of[rb] = ra;
            end
            joins++;
         end else begin
            covered = NODES - 1;
            // each label spends one member of its set unless the set is cyclic
            for (int unsigned i = 1; i < NODES; i++) begin
               id = find_root(i);
               if (!cyclic[id]) begin
                  if (members[id] <= 1) begin
                     covered = i - 1;
                     break;
                  end
                  members[id]--;
               end
            end
            clear_forest();
            want.kind  = KIND_PREFIX;
            want.count = covered[IN_W-1:0];
            if (covered > best_cover) best_cover = covered;
            finishes++;
         end
         answers_q.push_back(want);
      endfunction

      function void check_result(cover_result_type got);
         cover_result_type want;
         responses++;
         if (answers_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: response %0d with nothing pending: %s%0d %s%0d %s%0d %s%0d",
                        responses, "kind=", got.kind, "root=", got.root,
                        "cycle=", got.closed, "count=", got.count);
            return;
         end
         want = answers_q.pop_front();
         if (got.kind !== want.kind || got.root !== want.root ||
             got.closed !== want.closed || got.count !== want.count) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("ERROR: response %0d expected kind=%0d root=%0d cycle=%0d count=%0d",
                        responses, want.kind, want.root, want.closed, want.count);
               $display("       got kind=%0d root=%0d cycle=%0d count=%0d",
                        got.kind, got.root, got.closed, got.count);
            end
         end
      endfunction

      function int pending();
         return answers_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ufc_req_if req_chan ();
   ufc_rsp_if rsp_chan ();

   union_find_cycle_prefix_cover u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ufc_cover_scoreboard sb = new();
   int                  items_sent;
   bit                  steady;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // monitor both channels at the rising edge
   always @(posedge clock) begin
      cover_result_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.action, req_chan.node_a, req_chan.node_b);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind   = rsp_chan.result_kind;
            got.root   = rsp_chan.set_root;
            got.closed = rsp_chan.closed_cycle;
            got.count  = rsp_chan.covered_count;
            sb.check_result(got);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (steady || roll < 13) return 0;
      if (roll < 19) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(logic act, logic [IN_W-1:0] a, logic [IN_W-1:0] b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.node_a <= a;
      req_chan.node_b <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic join_nodes(logic [IN_W-1:0] a, logic [IN_W-1:0] b);
      send_item(ACT_JOIN, a, b);
   endtask

   task automatic request_cover();
      send_item(ACT_FINISH, IN_W'($urandom), IN_W'($urandom));
   endtask

   // hold the request side low until every response is back
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin : receiver
      int run;
      bit level;
      run = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin level = 1'b1; run = $urandom_range(1, 12);    end
               6:                begin level = 1'b1; run = $urandom_range(100, 300); end
               7, 8:             begin level = 1'b0; run = $urandom_range(1, 3);     end
               default:          begin level = 1'b0; run = $urandom_range(15, 60);   end
            endcase
            rsp_chan.ready <= level;
         end
         run--;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int span;
      int n_joins;
      int roll;
      logic [IN_W-1:0] a;
      logic [IN_W-1:0] b;

      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.action = ACT_JOIN;
      req_chan.node_a = '0;
      req_chan.node_b = '0;
      items_sent      = 0;
      steady          = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty forest, self join, label zero, top label, small rings
      request_cover();
      join_nodes(1, 1);
      join_nodes(16383, 0);
      join_nodes(0, 16383);
      send_item(ACT_FINISH, 16383, 16383);
      join_nodes(2, 1);
      join_nodes(1, 3);
      join_nodes(3, 2);
      join_nodes(4, 3);
      request_cover();
      join_nodes(1, 2);
      join_nodes(2, 3);
      request_cover();
      join_nodes(8191, 8192);
      join_nodes(10922, 5461);
      drain();
      request_cover();

      // random epochs: build a forest over a label window, then ask for cover
      while (items_sent < TOTAL_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         roll   = $urandom_range(0, 19);
         if (roll < 8)       span = $urandom_range(2, 16);
         else if (roll < 15) span = $urandom_range(17, 80);
         else if (roll < 18) span = $urandom_range(81, 400);
         else                span = NODES - 1;
         // close a ring over the whole window so the prefix reaches far
         if (span <= 200 && items_sent + span < TOTAL_ITEMS &&
             $urandom_range(0, 2) == 0) begin
            for (int k = 1; k < span; k++) begin
               if ($urandom_range(0, 1) == 1) join_nodes(IN_W'(k), IN_W'(k + 1));
               else join_nodes(IN_W'(k + 1), IN_W'(k));
            end
            join_nodes(IN_W'(span), 1);
         end
         n_joins = $urandom_range(10, 110);
         for (int k = 0; k < n_joins && items_sent < TOTAL_ITEMS; k++) begin
            roll = $urandom_range(0, 19);
            if (roll < 2) begin
               a = IN_W'($urandom);
               b = IN_W'($urandom);
            end else if (roll == 2) begin
               a = IN_W'($urandom_range(0, span));
               b = a;
            end else begin
               a = IN_W'($urandom_range(0, span));
               b = IN_W'($urandom_range(0, span));
            end
            join_nodes(a, b);
         end
         if ($urandom_range(0, 1) == 1) drain();
         request_cover();
         if ($urandom_range(0, 9) == 0) request_cover();
      end

      drain();
      repeat (50) @(negedge clock);
      $display("Run covered %0d joins (%0d closing a cycle) and %0d cover requests",
               sb.joins, sb.cycles_closed, sb.finishes);
      $display("Largest covered prefix %0d, %0d responses checked, %0d errors",
               sb.best_cover, sb.responses, sb.errors);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/ufc_pkg.sv
rtl/ufc_req_if.sv
rtl/ufc_rsp_if.sv
rtl/ufc_dpath.sv
rtl/ufc_ctrl.sv
rtl/union_find_cycle_prefix_cover.sv
rtl/ufc_chk.sv
sim/union_find_cycle_prefix_cover_test.sv
